@@ rtl/jts_pkg.sv @@
// ---------------------------------------------------------------------------
// jts_pkg
// Shared types, token codes and keyword tables for the JSON token scanner.
// ---------------------------------------------------------------------------
package jts_pkg;

  // Scan modes
  typedef enum logic [2:0] {
    MODE_DEFAULT      = 3'd0,
    MODE_STRING       = 3'd1,
    MODE_ESCAPE       = 3'd2,
    MODE_NUMBER       = 3'd3,
    MODE_AFTER_PERIOD = 3'd4,
    MODE_KEYWORD      = 3'd5,
    MODE_HALTED       = 3'd6
  } mode_t;

  // Token kinds
  localparam logic [3:0] KIND_LBRACE      = 4'd0;
  localparam logic [3:0] KIND_RBRACE      = 4'd1;
  localparam logic [3:0] KIND_LBRACKET    = 4'd2;
  localparam logic [3:0] KIND_RBRACKET    = 4'd3;
  localparam logic [3:0] KIND_COMMA       = 4'd4;
  localparam logic [3:0] KIND_COLON       = 4'd5;
  localparam logic [3:0] KIND_TRUE        = 4'd6;
  localparam logic [3:0] KIND_FALSE       = 4'd7;
  localparam logic [3:0] KIND_NULL        = 4'd8;
  localparam logic [3:0] KIND_STRING_BYTE = 4'd9;
  localparam logic [3:0] KIND_STRING_END  = 4'd10;
  localparam logic [3:0] KIND_NUMBER      = 4'd11;
  localparam logic [3:0] KIND_ERROR       = 4'd12;

  // Error codes
  localparam logic [1:0] ERR_ILLEGAL_CHAR = 2'd0;
  localparam logic [1:0] ERR_BAD_ESCAPE   = 2'd1;
  localparam logic [1:0] ERR_LONE_MINUS   = 2'd2;

  // Keyword selects
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_TAB     = 8'h09;

  typedef struct packed {
    logic [7:0] current_char;
    logic [7:0] next_char;
    logic       lookahead_valid;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [7:0]  content_byte;
    logic        ends_token;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [1:0]  error_code;
  } out_word_t;

  // Lexer decision for one byte
  typedef struct packed {
    logic       emit;
    logic [3:0] kind;
    logic [7:0] content;
    logic       ends;
    logic [1:0] err;
  } lex_res_t;

  function automatic logic [2:0] kw_len(input logic [1:0] sel);
    return (sel == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [3:0] kw_kind(input logic [1:0] sel);
    case (sel)
      KW_TRUE:  return KIND_TRUE;
      KW_FALSE: return KIND_FALSE;
      default:  return KIND_NULL;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (sel)
      KW_TRUE: begin
        case (pos)
          3'd0:    ch = "t";
          3'd1:    ch = "r";
          3'd2:    ch = "u";
          3'd3:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (pos)
          3'd0:    ch = "f";
          3'd1:    ch = "a";
          3'd2:    ch = "l";
          3'd3:    ch = "s";
          3'd4:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0:    ch = "n";
          3'd1:    ch = "u";
          3'd2:    ch = "l";
          3'd3:    ch = "l";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/jts_counter.sv @@
// ---------------------------------------------------------------------------
// jts_counter
// Saturating line and column counters; shows post-update values.
// ---------------------------------------------------------------------------
module jts_counter #(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   count_en,
  input  logic [7:0]             current_char,
  output logic [LINE_BITS-1:0]   line_next,
  output logic [COLUMN_BITS-1:0] column_next
);

  logic [LINE_BITS-1:0]   line_count;
  logic [COLUMN_BITS-1:0] column_count;
  logic                   is_newline;

  assign is_newline = (current_char == jts_pkg::CHAR_NEWLINE);

  always_comb begin
    line_next   = line_count;
    column_next = column_count;
    if (is_newline) begin
      if (!(&line_count)) begin
        line_next = line_count + LINE_BITS'(1);
      end
      column_next = '0;
    end else if (!(&column_count)) begin
      column_next = column_count + COLUMN_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= LINE_BITS'(1);
      column_count <= '0;
    end else if (count_en) begin
      line_count   <= line_next;
      column_count <= column_next;
    end
  end

endmodule

@@ rtl/jts_lexer.sv @@
// ---------------------------------------------------------------------------
// jts_lexer
// Scan-mode state machine: keyword matching, strings, escapes, numbers.
// ---------------------------------------------------------------------------
module jts_lexer (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  jts_pkg::in_word_t item,
  output jts_pkg::lex_res_t res,
  output logic              halted
);

  jts_pkg::mode_t mode, mode_next;
  logic [1:0]     keyword_select, keyword_select_next;
  logic [2:0]     keyword_position, keyword_position_next;

  logic [7:0] c;
  logic       next_digit;
  logic       next_period;
  logic       cur_digit;

  assign c           = item.current_char;
  assign cur_digit   = (c inside {[8'h30:8'h39]});
  assign next_digit  = item.lookahead_valid && (item.next_char inside {[8'h30:8'h39]});
  assign next_period = item.lookahead_valid && (item.next_char == ".");
  assign halted      = (mode == jts_pkg::MODE_HALTED);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= jts_pkg::MODE_DEFAULT;
      keyword_select   <= '0;
      keyword_position <= '0;
    end else if (step) begin
      mode             <= mode_next;
      keyword_select   <= keyword_select_next;
      keyword_position <= keyword_position_next;
    end
  end

  always_comb begin
    mode_next             = mode;
    keyword_select_next   = keyword_select;
    keyword_position_next = keyword_position;
    res                   = '0;
    case (mode)
      jts_pkg::MODE_ESCAPE: begin
        mode_next = jts_pkg::MODE_STRING;
        res.emit  = 1'b1;
        res.kind  = jts_pkg::KIND_STRING_BYTE;
        case (c)
          "n":     res.content = jts_pkg::CHAR_NEWLINE;
          "t":     res.content = jts_pkg::CHAR_TAB;
          "\\":    res.content = "\\";
          "\"":    res.content = "\"";
          default: begin
            mode_next = jts_pkg::MODE_HALTED;
            res.kind  = jts_pkg::KIND_ERROR;
            res.err   = jts_pkg::ERR_BAD_ESCAPE;
          end
        endcase
      end
      jts_pkg::MODE_AFTER_PERIOD: begin
        res.emit    = 1'b1;
        res.kind    = jts_pkg::KIND_NUMBER;
        res.content = c;
        if (!next_digit) begin
          mode_next = jts_pkg::MODE_DEFAULT;
          res.ends  = 1'b1;
        end
      end
      jts_pkg::MODE_NUMBER: begin
        res.emit    = 1'b1;
        res.kind    = jts_pkg::KIND_NUMBER;
        res.content = c;
        if (next_period) begin
          mode_next = jts_pkg::MODE_AFTER_PERIOD;
        end else if (!next_digit) begin
          mode_next = jts_pkg::MODE_DEFAULT;
          res.ends  = 1'b1;
        end
      end
      jts_pkg::MODE_STRING: begin
        if (c == "\\") begin
          mode_next = jts_pkg::MODE_ESCAPE;
        end else if (c == "\"") begin
          mode_next = jts_pkg::MODE_DEFAULT;
          res.emit  = 1'b1;
          res.kind  = jts_pkg::KIND_STRING_END;
          res.ends  = 1'b1;
        end else begin
          res.emit    = 1'b1;
          res.kind    = jts_pkg::KIND_STRING_BYTE;
          res.content = c;
        end
      end
      jts_pkg::MODE_KEYWORD: begin
        if (keyword_position >= jts_pkg::kw_len(keyword_select) ||
            c != jts_pkg::kw_char(keyword_select, keyword_position)) begin
          mode_next = jts_pkg::MODE_DEFAULT;
        end else begin
          keyword_position_next = keyword_position + 3'd1;
          if (keyword_position_next == jts_pkg::kw_len(keyword_select)) begin
            mode_next = jts_pkg::MODE_DEFAULT;
            res.emit  = 1'b1;
            res.kind  = jts_pkg::kw_kind(keyword_select);
            res.ends  = 1'b1;
          end
        end
      end
      jts_pkg::MODE_DEFAULT: begin
        case (c)
          jts_pkg::CHAR_NEWLINE, jts_pkg::CHAR_TAB, " ": ;
          "{": begin res.emit = 1'b1; res.kind = jts_pkg::KIND_LBRACE;   res.ends = 1'b1; end
          "}": begin res.emit = 1'b1; res.kind = jts_pkg::KIND_RBRACE;   res.ends = 1'b1; end
          "[": begin res.emit = 1'b1; res.kind = jts_pkg::KIND_LBRACKET; res.ends = 1'b1; end
          "]": begin res.emit = 1'b1; res.kind = jts_pkg::KIND_RBRACKET; res.ends = 1'b1; end
          ",": begin res.emit = 1'b1; res.kind = jts_pkg::KIND_COMMA;    res.ends = 1'b1; end
          ":": begin res.emit = 1'b1; res.kind = jts_pkg::KIND_COLON;    res.ends = 1'b1; end
          "t", "f", "n": begin
            keyword_select_next   = (c == "t") ? jts_pkg::KW_TRUE :
                                    (c == "f") ? jts_pkg::KW_FALSE : jts_pkg::KW_NULL;
            keyword_position_next = 3'd1;
            mode_next             = jts_pkg::MODE_KEYWORD;
          end
          "\"": mode_next = jts_pkg::MODE_STRING;
          "-": begin
            res.emit = 1'b1;
            if (!next_digit) begin
              mode_next = jts_pkg::MODE_HALTED;
              res.kind  = jts_pkg::KIND_ERROR;
              res.err   = jts_pkg::ERR_LONE_MINUS;
            end else begin
              mode_next   = jts_pkg::MODE_NUMBER;
              res.kind    = jts_pkg::KIND_NUMBER;
              res.content = c;
            end
          end
          default: begin
            res.emit = 1'b1;
            if (cur_digit) begin
              res.kind    = jts_pkg::KIND_NUMBER;
              res.content = c;
              if (!next_period && !next_digit) begin
                res.ends = 1'b1;
              end else begin
                mode_next = jts_pkg::MODE_NUMBER;
              end
            end else begin
              mode_next = jts_pkg::MODE_HALTED;
              res.kind  = jts_pkg::KIND_ERROR;
              res.err   = jts_pkg::ERR_ILLEGAL_CHAR;
            end
          end
        endcase
      end
      default: ; // halted: ignore everything
    endcase
  end

endmodule

@@ rtl/json_token_scanner.sv @@
// ---------------------------------------------------------------------------
// json_token_scanner
// Byte-at-a-time JSON tokenizer with line/column tracking.
// ---------------------------------------------------------------------------
// A taken byte waits in the input stage until the output can take a token;
//   it is decoded then, and its token (if any) goes into the output register.
// Throughput: one byte per cycle while the token port is not stalled.
// Output register lets the next byte be taken while a token waits.
// Reset (rst, sync, high): default mode, line 1, column 0, both ports empty.
// After an error token the scanner halts and drops all bytes until reset.
// ---------------------------------------------------------------------------
module json_token_scanner #(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // byte input
  input  logic               byte_valid,
  output logic               byte_stall,
  input  jts_pkg::in_word_t  byte_data,
  // token output
  output logic               token_valid,
  input  logic               token_stall,
  output jts_pkg::out_word_t token_data
);

  // Input stage
  logic              in_full;
  jts_pkg::in_word_t in_word;

  // Decode fires when the input stage holds a byte and the output can take one
  logic              step;
  logic              halted;
  jts_pkg::lex_res_t res;

  logic [LINE_BITS-1:0]   line_next;
  logic [COLUMN_BITS-1:0] column_next;

  // zero-extend so the low 16 bits are always there
  logic [LINE_BITS+15:0]   line_ext;
  logic [COLUMN_BITS+15:0] column_ext;

  assign step       = in_full && (!token_valid || !token_stall);
  assign byte_stall = in_full && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_word <= byte_data;
    end
  end

  jts_lexer u_lexer (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_word),
    .res    (res),
    .halted (halted)
  );

  // counters frozen once halted
  jts_counter #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_counter (
    .clk          (clk),
    .rst          (rst),
    .count_en     (step && !halted),
    .current_char (in_word.current_char),
    .line_next    (line_next),
    .column_next  (column_next)
  );

  assign line_ext   = {16'b0, line_next};
  assign column_ext = {16'b0, column_next};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (step) begin
      token_valid <= res.emit;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      token_data.token_kind    <= res.kind;
      token_data.content_byte  <= res.content;
      token_data.ends_token    <= res.ends;
      token_data.line_number   <= line_ext[15:0];
      token_data.column_number <= column_ext[15:0];
      token_data.error_code    <= res.err;
    end
  end

  // Assertions
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> token_data.token_kind <= jts_pkg::KIND_ERROR)
    else $error("token kind out of range");

  a_err_code_clear: assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_data.token_kind != jts_pkg::KIND_ERROR)
      |-> token_data.error_code == 2'd0)
    else $error("error code set on non-error token");

  a_silent_after_error: assert property (@(posedge clk) disable iff (rst)
    (token_valid && !token_stall && token_data.token_kind == jts_pkg::KIND_ERROR)
      |=> !token_valid)
    else $error("token after error");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> in_full && token_valid && token_stall)
    else $error("input stalled without back-pressure");

endmodule

@@ tb/tb_json_token_scanner.sv @@
// ---------------------------------------------------------------------------
// tb_json_token_scanner
// Self-checking bench for the byte-at-a-time JSON token scanner. A token
// ledger re-scans every accepted byte and lines up the tokens it predicts;
// each token the scanner hands out is checked field by field, in order.
// Stimulus is a stream of JSON fragments with random content, some broken
// on purpose, run under several idle/stall mixes. A single error at the
// very end (its kind picked at random) halts the scanner.
// ---------------------------------------------------------------------------
module tb_json_token_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200_000;

  // Scanner state as the ledger sees it
  typedef struct {
    jts_pkg::mode_t mode;
    logic [1:0]     kw_sel;
    logic [2:0]     kw_pos;
    logic [15:0]    line;
    logic [15:0]    col;
  } scan_state_t;

  // -------------------------------------------------------------------------
  // Token ledger: predicts tokens from accepted bytes, checks handed-out ones
  // -------------------------------------------------------------------------
  class token_ledger;
    scan_state_t        state;
    jts_pkg::out_word_t expected_tokens[$];
    int                 mismatches;
    int                 checked;

    function new();
      state.mode   = jts_pkg::MODE_DEFAULT;
      state.kw_sel = jts_pkg::KW_TRUE;
      state.kw_pos = '0;
      state.line   = 16'd1;
      state.col    = 16'd0;
      mismatches   = 0;
      checked      = 0;
    endfunction

    // Scan one byte against state s; returns 1 when a token comes out.
    function bit scan_byte(inout scan_state_t s, input jts_pkg::in_word_t w,
                           output jts_pkg::out_word_t tok);
      logic [7:0] c;
      bit         nd;
      bit         np;
      bit         hit;
      logic [3:0] kind;
      logic [7:0] data;
      logic       fin;
      logic [1:0] err;
      string      word;
      c    = w.current_char;
      nd   = w.lookahead_valid && (w.next_char >= "0") && (w.next_char <= "9");
      np   = w.lookahead_valid && (w.next_char == ".");
      hit  = 1'b0;
      kind = '0;
      data = '0;
      fin  = 1'b0;
      err  = '0;
      tok  = '0;
      if (s.mode >= jts_pkg::MODE_HALTED) return 1'b0;

      if (c == jts_pkg::CHAR_NEWLINE) begin
        if (s.line != 16'hFFFF) s.line = s.line + 16'd1;
        s.col = '0;
      end else if (s.col != 16'hFFFF) begin
        s.col = s.col + 16'd1;
      end

      case (s.mode)
        jts_pkg::MODE_ESCAPE: begin
          s.mode = jts_pkg::MODE_STRING;
          hit    = 1'b1;
          kind   = jts_pkg::KIND_STRING_BYTE;
          case (c)
            "n":        data = jts_pkg::CHAR_NEWLINE;
            "t":        data = jts_pkg::CHAR_TAB;
            "\\", "\"": data = c;
            default: begin
              kind   = jts_pkg::KIND_ERROR;
              err    = jts_pkg::ERR_BAD_ESCAPE;
              s.mode = jts_pkg::MODE_HALTED;
            end
          endcase
        end
        jts_pkg::MODE_NUMBER, jts_pkg::MODE_AFTER_PERIOD: begin
          hit  = 1'b1;
          kind = jts_pkg::KIND_NUMBER;
          data = c;
          if (s.mode == jts_pkg::MODE_NUMBER && np) begin
            s.mode = jts_pkg::MODE_AFTER_PERIOD;
          end else if (!nd) begin
            s.mode = jts_pkg::MODE_DEFAULT;
            fin    = 1'b1;
          end
        end
        jts_pkg::MODE_STRING: begin
          if (c == "\\") begin
            s.mode = jts_pkg::MODE_ESCAPE;
          end else if (c == "\"") begin
            s.mode = jts_pkg::MODE_DEFAULT;
            hit    = 1'b1;
            kind   = jts_pkg::KIND_STRING_END;
            fin    = 1'b1;
          end else begin
            hit  = 1'b1;
            kind = jts_pkg::KIND_STRING_BYTE;
            data = c;
          end
        end
        jts_pkg::MODE_KEYWORD: begin
          case (s.kw_sel)
            jts_pkg::KW_TRUE:  word = "true";
            jts_pkg::KW_FALSE: word = "false";
            default:           word = "null";
          endcase
          if (s.kw_pos >= word.len() || c != word[s.kw_pos]) begin
            s.mode = jts_pkg::MODE_DEFAULT;    // mismatch drops the byte
          end else begin
            s.kw_pos = s.kw_pos + 3'd1;
            if (s.kw_pos == word.len()) begin
              s.mode = jts_pkg::MODE_DEFAULT;
              hit    = 1'b1;
              fin    = 1'b1;
              kind   = (s.kw_sel == jts_pkg::KW_TRUE)  ? jts_pkg::KIND_TRUE :
                       (s.kw_sel == jts_pkg::KW_FALSE) ? jts_pkg::KIND_FALSE :
                                                         jts_pkg::KIND_NULL;
            end
          end
        end
        default: begin
          case (c)
            jts_pkg::CHAR_NEWLINE, jts_pkg::CHAR_TAB, " ": ;
            "{": begin hit = 1'b1; kind = jts_pkg::KIND_LBRACE;   fin = 1'b1; end
            "}": begin hit = 1'b1; kind = jts_pkg::KIND_RBRACE;   fin = 1'b1; end
            "[": begin hit = 1'b1; kind = jts_pkg::KIND_LBRACKET; fin = 1'b1; end
            "]": begin hit = 1'b1; kind = jts_pkg::KIND_RBRACKET; fin = 1'b1; end
            ",": begin hit = 1'b1; kind = jts_pkg::KIND_COMMA;    fin = 1'b1; end
            ":": begin hit = 1'b1; kind = jts_pkg::KIND_COLON;    fin = 1'b1; end
            "t", "f", "n": begin
              s.kw_sel = (c == "t") ? jts_pkg::KW_TRUE :
                         (c == "f") ? jts_pkg::KW_FALSE : jts_pkg::KW_NULL;
              s.kw_pos = 3'd1;
              s.mode   = jts_pkg::MODE_KEYWORD;
            end
            "\"": s.mode = jts_pkg::MODE_STRING;
            "-": begin
              hit = 1'b1;
              if (!nd) begin
                kind   = jts_pkg::KIND_ERROR;
                err    = jts_pkg::ERR_LONE_MINUS;
                s.mode = jts_pkg::MODE_HALTED;
              end else begin
                kind   = jts_pkg::KIND_NUMBER;
                data   = c;
                s.mode = jts_pkg::MODE_NUMBER;
              end
            end
            default: begin
              hit = 1'b1;
              if (c >= "0" && c <= "9") begin
                kind = jts_pkg::KIND_NUMBER;
                data = c;
                if (!np && !nd) fin = 1'b1;
                else s.mode = jts_pkg::MODE_NUMBER;
              end else begin
                kind   = jts_pkg::KIND_ERROR;
                err    = jts_pkg::ERR_ILLEGAL_CHAR;
                s.mode = jts_pkg::MODE_HALTED;
              end
            end
          endcase
        end
      endcase

      tok.token_kind    = kind;
      tok.content_byte  = data;
      tok.ends_token    = fin;
      tok.line_number   = s.line;
      tok.column_number = s.col;
      tok.error_code    = err;
      return hit;
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    function void note_byte(input jts_pkg::in_word_t w);
      jts_pkg::out_word_t t;
      if (scan_byte(state, w, t)) expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    task check_token(input jts_pkg::out_word_t got);
      jts_pkg::out_word_t want;
      if (expected_tokens.size() == 0) begin
        report($sformatf("token kind %0d with nothing expected", got.token_kind));
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      if (got.token_kind != want.token_kind)
        report($sformatf("token_kind %0d, want %0d", got.token_kind, want.token_kind));
      if (got.content_byte != want.content_byte)
        report($sformatf("content_byte %h, want %h", got.content_byte, want.content_byte));
      if (got.ends_token != want.ends_token)
        report($sformatf("ends_token %b, want %b", got.ends_token, want.ends_token));
      if (got.line_number != want.line_number)
        report($sformatf("line_number %0d, want %0d", got.line_number, want.line_number));
      if (got.column_number != want.column_number)
        report($sformatf("column_number %0d, want %0d",
                         got.column_number, want.column_number));
      if (got.error_code != want.error_code)
        report($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
    endtask
  endclass

  // -------------------------------------------------------------------------
  // DUT and its surroundings
  // -------------------------------------------------------------------------
  logic               clk;
  logic               rst;
  logic               byte_valid;
  logic               byte_stall;
  jts_pkg::in_word_t  byte_data;
  logic               token_valid;
  logic               token_stall;
  jts_pkg::out_word_t token_data;

  json_token_scanner uut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_data   (byte_data),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_data  (token_data)
  );

  token_ledger ledger = new();

  scan_state_t shadow;        // state after every byte generated so far
  logic [7:0]  text_q[$];     // JSON text waiting to go out
  int          idle_in;       // sender idle chance, percent
  int          stall_pct;     // receiver stall chance, percent
  bit          la_noise;      // corrupt the lookahead now and then
  bit          halt_ok;       // errors allowed (final part only)
  int          bytes_sent;
  int          cycle_count;

  always #5 clk = ~clk;

  // Receiver: random stall at the phase's rate
  always @(posedge clk) begin
    token_stall <= ($urandom_range(99) < stall_pct);
  end

  // Both handshakes are judged on values seen at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) ledger.note_byte(byte_data);
      if (token_valid && !token_stall) ledger.check_token(token_data);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d tokens still due",
               cycle_count, ledger.expected_tokens.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Driving
  // -------------------------------------------------------------------------

  // Present one word, holding it until the scanner takes it.
  task automatic drive_byte(input jts_pkg::in_word_t w);
    while ($urandom_range(99) < idle_in) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= w;
    do @(posedge clk); while (byte_stall);
  endtask

  // Send one byte. Outside the final part, a byte that would halt the
  // scanner is swapped for one its current mode always accepts.
  task automatic send_one(input logic [7:0] c, input logic [7:0] nx, input bit la);
    jts_pkg::in_word_t  w;
    scan_state_t        probe;
    jts_pkg::out_word_t t;
    w.current_char    = c;
    w.next_char       = nx;
    w.lookahead_valid = la;
    probe = shadow;
    if (ledger.scan_byte(probe, w, t) && t.token_kind == jts_pkg::KIND_ERROR && !halt_ok)
    begin
      // quote / space
      w.current_char = (shadow.mode == jts_pkg::MODE_ESCAPE) ? 8'(34) : 8'(32);
      probe = shadow;
      void'(ledger.scan_byte(probe, w, t));
    end
    shadow = probe;
    bytes_sent++;
    drive_byte(w);
  endtask

  // Pop the head of the text; lookahead is the byte behind it, if any.
  task automatic send_next();
    logic [7:0] c;
    logic [7:0] nx;
    bit         la;
    c  = text_q.pop_front();
    la = (text_q.size() != 0);
    nx = la ? text_q[0] : 8'($urandom_range(255));
    if (la_noise && $urandom_range(15) == 0) la = 1'b0;
    if (la_noise && $urandom_range(15) == 0) nx = 8'($urandom_range(255));
    send_one(c, nx, la);
  endtask

  task automatic drain_text();
    while (text_q.size() != 0) send_next();
  endtask

  task automatic add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Append one JSON fragment; most are well formed, some are not.
  task automatic add_fragment();
    int    r;
    int    n;
    string kw;
    string esc;
    r   = $urandom_range(99);
    esc = "nt\\\"";
    case ($urandom_range(2))
      0:       kw = "true";
      1:       kw = "false";
      default: kw = "null";
    endcase
    if (r < 14) begin
      push_text("{}[],:");
      n = $urandom_range(5);
      text_q = {text_q[0:text_q.size()-7], text_q[text_q.size()-6+n]};
    end else if (r < 26) begin
      case ($urandom_range(2))
        0:       add_byte(" ");
        1:       add_byte(jts_pkg::CHAR_TAB);
        default: add_byte(jts_pkg::CHAR_NEWLINE);
      endcase
    end else if (r < 40) begin
      push_text(kw);
    end else if (r < 48) begin
      // keyword cut short, then any byte
      push_text(kw.substr(0, $urandom_range(kw.len() - 2)));
      add_byte(8'($urandom_range(255)));
    end else if (r < 70) begin
      add_byte("\"");
      repeat ($urandom_range(6)) begin
        if ($urandom_range(99) < 25) begin
          add_byte("\\");
          add_byte(esc[$urandom_range(3)]);
        end else begin
          add_byte(8'($urandom_range(255)));
        end
      end
      add_byte("\"");
    end else if (r < 88) begin
      if ($urandom_range(1)) add_byte("-");
      repeat ($urandom_range(1, 4)) add_byte(8'("0" + $urandom_range(9)));
      if ($urandom_range(99) < 40) begin
        add_byte(".");
        repeat ($urandom_range(0, 3)) add_byte(8'("0" + $urandom_range(9)));
      end
    end else begin
      add_byte(8'($urandom_range(255)));
    end
  endtask

  // Walk the scanner back to default mode without an error.
  task automatic settle();
    while (shadow.mode != jts_pkg::MODE_DEFAULT) begin
      case (shadow.mode)
        jts_pkg::MODE_STRING, jts_pkg::MODE_ESCAPE: send_one("\"", " ", 1'b1);
        jts_pkg::MODE_KEYWORD:                      send_one(" ", " ", 1'b1);
        default:                                    send_one("0", " ", 1'b0);
      endcase
    end
  endtask

  task automatic set_phase(input int in_pct, input int out_pct);
    idle_in   = in_pct;
    stall_pct <= out_pct;
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    int         p;
    logic [1:0] final_err;
    clk         = 1'b0;
    rst         = 1'b1;
    byte_valid  = 1'b0;
    byte_data   = '0;
    token_stall = 1'b0;
    idle_in     = 0;
    stall_pct   = 0;
    la_noise    = 1'b0;
    halt_ok     = 1'b0;
    bytes_sent  = 0;
    cycle_count = 0;
    shadow      = ledger.state;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: object with a string holding NUL, 0xFF and all four escapes,
    // a signed fraction, a single digit, a cut-short keyword whose mismatch
    // byte is dropped, and a trailing digit with no lookahead.
    push_text("{\"");
    add_byte(8'h00);
    add_byte(8'hFF);
    push_text("\\\"\\\\\\n\\t\":[-1.5,7,tru]}3");
    drain_text();

    // Random fragments under four idle/stall mixes
    la_noise = 1'b1;
    for (p = 0; p < 4; p++) begin
      case (p)
        0:       set_phase(0, 0);
        1:       set_phase(61, 0);
        2:       set_phase(0, 61);
        default: set_phase(24, 24);
      endcase
      repeat (363) begin
        if (text_q.size() < 2) add_fragment();
        send_next();
      end
    end
    drain_text();
    settle();

    // Clean tail with exact lookahead
    la_noise = 1'b0;
    push_text("[\"a\",-0.25,null]");
    set_phase(24, 24);
    drain_text();

    // One error ends it; afterwards the scanner must stay silent
    halt_ok   = 1'b1;
    final_err = 2'($urandom_range(2));
    case (final_err)
      jts_pkg::ERR_ILLEGAL_CHAR: send_one("#", " ", 1'b1);
      jts_pkg::ERR_BAD_ESCAPE: begin
        send_one("\"", "\\", 1'b1);
        send_one("\\", "q", 1'b1);
        send_one("q", " ", 1'b1);
      end
      default: send_one("-", "x", 1'b1);
    endcase
    send_one("{", "7", 1'b1);
    send_one("7", "8", 1'b1);
    send_one(jts_pkg::CHAR_NEWLINE, " ", 1'b0);
    byte_valid <= 1'b0;

    while (ledger.expected_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (ledger.expected_tokens.size() != 0)
      ledger.report($sformatf("%0d tokens never came", ledger.expected_tokens.size()));

    $display("Scanned %0d bytes (directed text, random fragments, 4 idle mixes), %0d tokens",
             bytes_sent, ledger.checked);
    $display("Run ended on error code %0d; %0d mismatches", final_err, ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/jts_pkg.sv
rtl/jts_counter.sv
rtl/jts_lexer.sv
rtl/json_token_scanner.sv
tb/tb_json_token_scanner.sv
